// ===== rtl/hsv2rgb_pkg.sv =====
// ============================================================================
// hsv2rgb_pkg
// Shared types and constants for the full-value HSV to RGB converter.
// ============================================================================
package hsv2rgb_pkg;

  // Input and result field widths
  localparam int unsigned CHAN_W = 8;

  // Clamp ceiling for hue and saturation, and the full drive level
  localparam logic [7:0] SCALE_MAX  = 8'd254;
  localparam logic [7:0] FULL_LEVEL = 8'd255;

  // Hue sector start points
  localparam logic [7:0] HUE_YG = 8'd43;
  localparam logic [7:0] HUE_GC = 8'd85;
  localparam logic [7:0] HUE_CB = 8'd128;
  localparam logic [7:0] HUE_BM = 8'd170;
  localparam logic [7:0] HUE_MR = 8'd212;

  // Ramp numerator width (numerator stays in 0..43)
  localparam int unsigned RAMP_W = 6;
  // Ramp product width (43 * 255 fits in 14 bits)
  localparam int unsigned PROD_W = 14;

  // Reciprocals for floor(p / 42) and floor(p / 43), exact for p < 2^14
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP_42 = 15'd24967;
  localparam logic [RECIP_W-1:0] RECIP_43 = 15'd24386;

  // Hue sectors: which channel is high, which one ramps
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,  // red full, green rising
    SEC_YG = 3'd1,  // green full, red falling
    SEC_GC = 3'd2,  // green full, blue rising (divide by 43)
    SEC_CB = 3'd3,  // blue full, green falling
    SEC_BM = 3'd4,  // blue full, red rising
    SEC_MR = 3'd5   // red full, blue falling
  } sector_t;

endpackage

// ===== rtl/hsv_to_rgb_converter.sv =====
// ============================================================================
// hsv_to_rgb_converter
// Full-value HSV to RGB conversion, four register stages, one item a clock unless stalled.
// ============================================================================
//
//  channel | dir | handshake          | payload (lowest bits first)
//  --------+-----+--------------------+----------------------------------
//  in_     | in  | in_tvalid/tready   | in_tdata:  hue[7:0], saturation[7:0]
//  out_    | out | out_tvalid/tready  | out_tdata: red, green, blue (8 each)
//
//  out_tvalid rises once the item has passed the stage registers v1_r, v2_r,
//  v3_r and out_valid_r in turn; the pipeline accepts one item every cycle
//  while the output is not stalled. The depth is set by the two multipliers:
//  ramp product in stage 2, reciprocal divide in stage 3.
//  Reset clears only the stage valid bits. Each stage holds while the next
//  one is full and stalled, so empty stages still fill during a stall.
//
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // hue[7:0], saturation[15:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  localparam int unsigned CW = hsv2rgb_pkg::CHAN_W;
  localparam int unsigned NW = hsv2rgb_pkg::RAMP_W;
  localparam int unsigned PW = hsv2rgb_pkg::PROD_W;
  localparam int unsigned MW = PW + hsv2rgb_pkg::RECIP_W;

  // Output scale by 256/254 with saturation: c + (c >= 127), 255 from 254 up
  function automatic logic [CW-1:0] scale_chan(input logic [CW-1:0] c);
    logic [CW-1:0] res;
    if (c >= 8'd254) begin
      res = hsv2rgb_pkg::FULL_LEVEL;
    end else if (c >= 8'd127) begin
      res = c + 8'd1;
    end else begin
      res = c;
    end
    return res;
  endfunction

  // Stage registers
  logic                   v1_r, v2_r, v3_r, out_valid_r;
  hsv2rgb_pkg::sector_t   sec1_r, sec2_r, sec3_r;
  logic [NW-1:0]          n1_r;
  logic [CW-1:0]          dl1_r, lo1_r, lo2_r, lo3_r;
  logic [PW-1:0]          p2_r;
  logic [CW-1:0]          q3_r;
  logic [CW-1:0]          red_r, green_r, blue_r;

  // Stage ready chain
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !out_valid_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // --------------------------------------------------------------------------
  // Stage 1: clamp, floor level, sector decode, ramp numerator
  // --------------------------------------------------------------------------
  logic [CW-1:0]        hue_c, sat_c, x_s1, lo_nxt, dl_nxt, n_full;
  hsv2rgb_pkg::sector_t sec_nxt;

  always_comb begin
    hue_c = (in_tdata[7:0] > hsv2rgb_pkg::SCALE_MAX) ? hsv2rgb_pkg::SCALE_MAX
                                                      : in_tdata[7:0];
    sat_c = (in_tdata[15:8] > hsv2rgb_pkg::SCALE_MAX) ? hsv2rgb_pkg::SCALE_MAX
                                                       : in_tdata[15:8];
    // 255*x/254 equals x, plus one only at x = 254
    x_s1   = hsv2rgb_pkg::SCALE_MAX - sat_c;
    lo_nxt = x_s1 + ((sat_c == 8'd0) ? 8'd1 : 8'd0);
    dl_nxt = hsv2rgb_pkg::FULL_LEVEL - lo_nxt;

    if (hue_c < hsv2rgb_pkg::HUE_YG) begin
      sec_nxt = hsv2rgb_pkg::SEC_RY;
      n_full  = hue_c;
    end else if (hue_c < hsv2rgb_pkg::HUE_GC) begin
      sec_nxt = hsv2rgb_pkg::SEC_YG;
      n_full  = 8'd84 - hue_c;
    end else if (hue_c < hsv2rgb_pkg::HUE_CB) begin
      sec_nxt = hsv2rgb_pkg::SEC_GC;
      n_full  = hue_c - 8'd84;
    end else if (hue_c < hsv2rgb_pkg::HUE_BM) begin
      sec_nxt = hsv2rgb_pkg::SEC_CB;
      n_full  = 8'd169 - hue_c;
    end else if (hue_c < hsv2rgb_pkg::HUE_MR) begin
      sec_nxt = hsv2rgb_pkg::SEC_BM;
      n_full  = hue_c - 8'd169;
    end else begin
      sec_nxt = hsv2rgb_pkg::SEC_MR;
      n_full  = hsv2rgb_pkg::SCALE_MAX - hue_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      sec1_r <= sec_nxt;
      n1_r   <= n_full[NW-1:0];
      dl1_r  <= dl_nxt;
      lo1_r  <= lo_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: ramp product n * delta
  // --------------------------------------------------------------------------
  logic [PW-1:0] p_nxt;

  assign p_nxt = PW'(n1_r) * PW'(dl1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      sec2_r <= sec1_r;
      p2_r   <= p_nxt;
      lo2_r  <= lo1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: divide by 42 or 43 through a reciprocal multiply
  // --------------------------------------------------------------------------
  logic [hsv2rgb_pkg::RECIP_W-1:0] recip;
  logic [MW-1:0]                   quot_prod;

  assign recip     = (sec2_r == hsv2rgb_pkg::SEC_GC) ? hsv2rgb_pkg::RECIP_43
                                                     : hsv2rgb_pkg::RECIP_42;
  assign quot_prod = MW'(p2_r) * MW'(recip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      sec3_r <= sec2_r;
      q3_r   <= quot_prod[hsv2rgb_pkg::RECIP_SHIFT +: CW];
      lo3_r  <= lo2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: channel routing, 256/254 scale, saturation
  // --------------------------------------------------------------------------
  logic [CW:0]   ramp_sum;
  logic [CW-1:0] ramp, r_c, g_c, b_c;

  always_comb begin
    ramp_sum = {1'b0, q3_r} + {1'b0, lo3_r};
    ramp     = ramp_sum[CW-1:0];
    unique case (sec3_r)
      hsv2rgb_pkg::SEC_RY: begin
        r_c = hsv2rgb_pkg::FULL_LEVEL; g_c = ramp; b_c = lo3_r;
      end
      hsv2rgb_pkg::SEC_YG: begin
        r_c = ramp; g_c = hsv2rgb_pkg::FULL_LEVEL; b_c = lo3_r;
      end
      hsv2rgb_pkg::SEC_GC: begin
        r_c = lo3_r; g_c = hsv2rgb_pkg::FULL_LEVEL; b_c = ramp;
      end
      hsv2rgb_pkg::SEC_CB: begin
        r_c = lo3_r; g_c = ramp; b_c = hsv2rgb_pkg::FULL_LEVEL;
      end
      hsv2rgb_pkg::SEC_BM: begin
        r_c = ramp; g_c = lo3_r; b_c = hsv2rgb_pkg::FULL_LEVEL;
      end
      hsv2rgb_pkg::SEC_MR: begin
        r_c = hsv2rgb_pkg::FULL_LEVEL; g_c = lo3_r; b_c = ramp;
      end
      default: begin
        r_c = lo3_r; g_c = lo3_r; b_c = lo3_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy4) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      red_r   <= scale_chan(r_c);
      green_r <= scale_chan(g_c);
      blue_r  <= scale_chan(b_c);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {blue_r, green_r, red_r};

`ifndef SYNTH
  // Ramp numerator never passes its divisor
  a_ramp_num: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (n1_r <= ((sec1_r == hsv2rgb_pkg::SEC_GC) ? 6'd43 : 6'd42)))
    else $error("ramp numerator out of range");

  // Quotient plus floor never exceeds full scale
  a_ramp_sum: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (({1'b0, q3_r} + {1'b0, lo3_r}) <= 9'd255))
    else $error("ramp sum overflow");

  // Input held off only when every stage is full
  a_backpress: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && out_valid_r))
    else $error("input stalled with a free stage");

  // A new result comes only from a valid stage 3 item
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v3_r))
    else $error("result without a source item");
`endif

endmodule

// ===== test/hsv_to_rgb_converter_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// hsv_to_rgb_converter_tb
// Stream testbench for the full-value HSV to RGB converter. Sends hue and
// saturation pairs, predicts each RGB triple in the bench and compares every
// output transfer in order. Both sides throttle at random, apart from one
// stretch that runs at full rate.
// ============================================================================
module hsv_to_rgb_converter_tb;

  localparam int unsigned IDLE_PCT   = 27;
  localparam int unsigned STALL_LIM  = 1000;
  localparam int unsigned DRAIN_CYC  = 12;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct {
    logic [7:0] hue;
    logic [7:0] sat;
    rgb_t       px;
  } pixel_exp_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;   // hue[7:0], saturation[15:8]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // red[7:0], green[15:8], blue[23:16]

  pixel_exp_t  rgb_queue[$];
  int unsigned err_cnt   = 0;
  int unsigned quiet_cyc = 0;
  logic        full_rate = 1'b0;

  hsv_to_rgb_converter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Scale a channel by 256/254 and clip at full level
  function automatic logic [7:0] scale_level(input int unsigned lvl);
    int unsigned v;
    v = (lvl * 256) / hsv2rgb_pkg::SCALE_MAX;
    return (v > hsv2rgb_pkg::FULL_LEVEL) ? hsv2rgb_pkg::FULL_LEVEL : v[7:0];
  endfunction

  // Expected RGB for one hue/saturation pair, value held at full scale
  function automatic rgb_t predict_rgb(input logic [7:0] hue, input logic [7:0] sat);
    int unsigned h, s, full, floor_lvl, swing, r, g, b;
    rgb_t px;
    full = 32'(hsv2rgb_pkg::FULL_LEVEL);
    h = 32'((hue > hsv2rgb_pkg::SCALE_MAX) ? hsv2rgb_pkg::SCALE_MAX : hue);
    s = 32'((sat > hsv2rgb_pkg::SCALE_MAX) ? hsv2rgb_pkg::SCALE_MAX : sat);
    floor_lvl = (full * (hsv2rgb_pkg::SCALE_MAX - s)) / hsv2rgb_pkg::SCALE_MAX;
    swing     = full - floor_lvl;
    if (h < hsv2rgb_pkg::HUE_YG) begin
      r = full;
      g = (h * swing) / 42 + floor_lvl;
      b = floor_lvl;
    end else if (h < hsv2rgb_pkg::HUE_GC) begin
      r = ((84 - h) * swing) / 42 + floor_lvl;
      g = full;
      b = floor_lvl;
    end else if (h < hsv2rgb_pkg::HUE_CB) begin
      r = floor_lvl;
      g = full;
      b = ((h - 84) * swing) / 43 + floor_lvl;
    end else if (h < hsv2rgb_pkg::HUE_BM) begin
      r = floor_lvl;
      g = ((169 - h) * swing) / 42 + floor_lvl;
      b = full;
    end else if (h < hsv2rgb_pkg::HUE_MR) begin
      r = ((h - 169) * swing) / 42 + floor_lvl;
      g = floor_lvl;
      b = full;
    end else begin
      r = full;
      g = floor_lvl;
      b = ((254 - h) * swing) / 42 + floor_lvl;
    end
    px.red   = scale_level(r);
    px.green = scale_level(g);
    px.blue  = scale_level(b);
    return px;
  endfunction

  // Send one pixel; random idle cycles ahead of it unless running full rate
  task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat);
    pixel_exp_t e;
    while (!full_rate && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sat, hue};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    e.hue = hue;
    e.sat = sat;
    e.px  = predict_rgb(hue, sat);
    rgb_queue.push_back(e);
  endtask

  // Pick a value with extra weight on the edges and the clamp code
  function automatic logic [7:0] pick_level();
    case ($urandom_range(9))
      0:       return 8'd0;
      1:       return hsv2rgb_pkg::SCALE_MAX;
      2:       return hsv2rgb_pkg::FULL_LEVEL;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Sector boundaries at full saturation, hue clamp included
  task automatic test_sector_bounds();
    logic [7:0] hues[14];
    hues = '{8'd0, 8'd42, 8'd43, 8'd84, 8'd85, 8'd127, 8'd128,
             8'd169, 8'd170, 8'd211, 8'd212, 8'd253, 8'd254, 8'd255};
    foreach (hues[i]) send_pixel(hues[i], hsv2rgb_pkg::SCALE_MAX);
  endtask

  // Grey, half saturation and the saturation clamp
  task automatic test_saturation_edges();
    send_pixel(8'd0,   8'd0);
    send_pixel(8'd100, 8'd0);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd21,  8'd127);
    send_pixel(8'd106, 8'd127);
    send_pixel(8'd190, 8'd1);
    send_pixel(8'd64,  8'd255);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd150, 8'd253);
  endtask

  // Random pixels with both sides throttling
  task automatic test_random_throttled(input int unsigned n);
    repeat (n) send_pixel(pick_level(), pick_level());
  endtask

  // Back-to-back pixels with the sink always ready
  task automatic test_random_full_rate(input int unsigned n);
    full_rate = 1'b1;
    repeat (n) send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)));
    full_rate = 1'b0;
  endtask

  // Sink side: random stalls except during the full-rate stretch
  always @(posedge clk) begin
    out_tready <= full_rate || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic check_level(input string name, input logic [7:0] hue,
                             input logic [7:0] sat, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch hue %0d sat %0d expected %0d actual %0d",
               $time, name, hue, sat, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Output checker: each transfer against the oldest expectation
  always @(posedge clk) begin
    pixel_exp_t e;
    rgb_t act;
    if (rst_n && out_tvalid && out_tready) begin
      act = out_tdata;
      if (rgb_queue.size() == 0) begin
        $display("%0t: unexpected output expected none actual %h", $time, out_tdata);
        err_cnt++;
      end else begin
        e = rgb_queue.pop_front();
        check_level("red",   e.hue, e.sat, e.px.red,   act.red);
        check_level("green", e.hue, e.sat, e.px.green, act.green);
        check_level("blue",  e.hue, e.sat, e.px.blue,  act.blue);
      end
    end
  end

  // Watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cyc <= 0;
      end else begin
        quiet_cyc <= quiet_cyc + 1;
      end
      if (quiet_cyc >= STALL_LIM) begin
        $display("hsv_to_rgb_converter test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_sector_bounds();
    test_saturation_edges();
    test_random_throttled(450);
    test_random_full_rate(300);
    test_random_throttled(277);

    in_tvalid <= 1'b0;
    while (rgb_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    if (err_cnt == 0) begin
      $display("hsv_to_rgb_converter test passed");
    end else begin
      $display("hsv_to_rgb_converter test failed");
    end
    $finish;
  end

endmodule
